>>> src/gabc_pkg.sv
// ----------------------------------------------------------------------------
// gabc_pkg: shared types and constants of the glyph atlas bucket cache
// Sizes of the bucket grid, codes of the item channel and the layout of the
// row word and glyph map entry that live in the state memories.
// ----------------------------------------------------------------------------
package gabc_pkg;

  localparam int EDGE     = 16;
  localparam int MAX_FREQ = 8;
  localparam int GLYPHS   = 1024;

  localparam int RW  = $clog2(EDGE);        // row and column index
  localparam int SW  = $clog2(EDGE + 1);    // span and per-row counts
  localparam int FW  = $clog2(MAX_FREQ);    // frequency class
  localparam int GW  = $clog2(GLYPHS);      // glyph index
  localparam int OPW = 2;
  localparam int STW = 3;

  localparam logic [OPW-1:0] OP_USE   = 2'd0;
  localparam logic [OPW-1:0] OP_FRAME = 2'd1;
  localparam logic [OPW-1:0] OP_PLACE = 2'd2;

  localparam logic [STW-1:0] ST_HIT    = 3'd0;
  localparam logic [STW-1:0] ST_NEW    = 3'd1;
  localparam logic [STW-1:0] ST_NOROOM = 3'd2;
  localparam logic [STW-1:0] ST_DONE   = 3'd3;
  localparam logic [STW-1:0] ST_EMPTY  = 3'd4;

  // One atlas row: owners, both frequency classes and both class counts.
  typedef struct packed {
    logic [EDGE-1:0]              own_v;
    logic [EDGE-1:0][GW-1:0]      own;
    logic [EDGE-1:0][FW-1:0]      cur;
    logic [EDGE-1:0][FW-1:0]      last;
    logic [MAX_FREQ-1:0][SW-1:0]  cnt;
    logic [MAX_FREQ-1:0][SW-1:0]  lcnt;
  } row_t;

  typedef struct packed {
    logic          mapped;
    logic [RW-1:0] row;
    logic [RW-1:0] col;
    logic [SW-1:0] span;
  } gmap_t;

  typedef struct packed {
    logic [RW-1:0] row_rd_addr;
    logic          row_we;
    logic [RW-1:0] row_wr_addr;
    row_t          row_wdata;
    logic [GW-1:0] gmap_rd_addr;
    logic          gmap_we;
    logic [GW-1:0] gmap_wr_addr;
    gmap_t         gmap_wdata;
  } store_req_t;

  // Fresh row: every bucket free and cold, all buckets in class zero.
  function automatic row_t row_reset();
    row_t w;
    w        = '0;
    w.cnt[0] = SW'(EDGE);
    return w;
  endfunction

endpackage

>>> src/gabc_if.sv
// ----------------------------------------------------------------------------
// gabc_if: item and result channels of the glyph atlas bucket cache
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface gabc_in_if import gabc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OPW-1:0] op;
  logic [GW-1:0]  glyph_index;
  logic [SW-1:0]  glyph_span;
  logic [RW-1:0]  row;
  logic [RW-1:0]  column;

  modport source (output valid, op, glyph_index, glyph_span, row, column, input ready);
  modport sink   (input valid, op, glyph_index, glyph_span, row, column, output ready);
endinterface

interface gabc_out_if import gabc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [STW-1:0] status;
  logic [RW-1:0]  mapped_row;
  logic [RW-1:0]  mapped_column;

  modport source (output valid, status, mapped_row, mapped_column, input ready);
  modport sink   (input valid, status, mapped_row, mapped_column, output ready);
endinterface

>>> src/glyph_atlas_bucket_cache.sv
// ----------------------------------------------------------------------------
// glyph_atlas_bucket_cache: frequency-aware bucket cache for a glyph atlas
// Sequencer that reads, updates and writes back atlas rows and glyph entries.
// ----------------------------------------------------------------------------
// Items arrive on in_if (op, glyph_index, glyph_span, row, column) and each
// gives exactly one result on out_if (status, mapped_row, mapped_column).
// The caching_enabled register sits at byte address 0 of the APB-style port;
// write it only while the block is idle, which the block does not enforce.
//
// The block works on one item at a time. Immediate answers (empty glyph,
// frame start with caching off, bad op, place out of the grid) go straight
// to out_if. A hit with caching on also loads its row, raises the class of
// each bucket of its span and writes the row back. A miss scans all EDGE
// rows through the single row memory read port, evicts the owners of the
// span buckets, maps the glyph and, with caching on, raises their classes.
// A place first unmaps the glyph if it is already mapped, then evicts and
// maps its span buckets. A frame start with caching on rewrites every row.
//
// After reset a clearing pass over all GLYPHS entries empties the glyph map
// and the rows; no item is taken meanwhile, configuration writes are.
// A result waits in the output register while the receiver stalls; the
// next item is taken and worked on, and stalls only when its own result
// is ready while the previous one still waits.
// ----------------------------------------------------------------------------
module glyph_atlas_bucket_cache import gabc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gabc_in_if.sink     in_if,
  gabc_out_if.source  out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_GCHK, S_SC_W, S_SC, S_UN_W, S_UN, S_LD_W, S_LD,
    S_EVICT, S_MAP, S_RAISE, S_WB, S_ROLL_W, S_ROLL, S_EMIT
  } state_t;

  state_t          state_r;
  logic            caching_r;
  logic [OPW-1:0]  op_r;
  logic [GW-1:0]   g_r;
  logic [SW-1:0]   span_r;
  logic [RW-1:0]   row_in_r;
  logic [RW-1:0]   tc_r;
  logic [RW-1:0]   rsel_r;
  logic [SW-1:0]   k_r;
  logic            hit_r;
  gmap_t           ent_r;
  row_t            rowq_r;
  logic            best_v_r;
  logic [FW-1:0]   best_f_r;
  logic [RW-1:0]   best_c_r;
  logic [RW-1:0]   best_r_r;
  logic [STW-1:0]  res_status_r;
  logic [RW-1:0]   res_row_r;
  logic [RW-1:0]   res_col_r;
  logic            out_valid_r;
  logic [STW-1:0]  out_status_r;
  logic [RW-1:0]   out_row_r;
  logic [RW-1:0]   out_col_r;

  store_req_t      req;
  row_t            row_rdata;
  gmap_t           gmap_rdata;
  logic            busy;

  gabc_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_i        (req),
    .row_rdata_o  (row_rdata),
    .gmap_rdata_o (gmap_rdata),
    .busy_o       (busy)
  );

  // Configuration port: one register, always ready.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {31'd0, caching_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caching_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      caching_r <= cfg_pwdata[0];
    end
  end

  assign in_if.ready      = (state_r == S_IDLE) && !busy;
  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.mapped_row    = out_row_r;
  assign out_if.mapped_column = out_col_r;

  function automatic logic in_win(int j, logic [RW-1:0] c, logic [SW-1:0] s);
    return (j >= int'(c)) && (j < int'(c) + int'(s));
  endfunction

  // Bucket under the eviction or raise cursor.
  logic [RW:0]   bk_sum;
  logic [RW-1:0] bk;
  assign bk_sum = {1'b0, tc_r} + k_r;
  assign bk     = bk_sum[RW-1:0];

  logic last_k;
  assign last_k = (SW'(k_r + 1'b1) == span_r);

  // Row scan: for every class, the first window of span buckets whose
  // current and last classes are both no hotter than that class.
  logic [MAX_FREQ-1:0]         cls_found;
  logic [MAX_FREQ-1:0][RW-1:0] cls_col;
  logic                        row_found;
  logic [FW-1:0]               row_f;
  logic [RW-1:0]               row_c;

  always_comb begin
    logic win;
    for (int f = 0; f < MAX_FREQ; f++) begin
      cls_found[f] = 1'b0;
      cls_col[f]   = '0;
      for (int c = EDGE - 1; c >= 0; c--) begin
        win = (c + int'(span_r)) <= EDGE;
        for (int j = 0; j < EDGE; j++) begin
          if (in_win(j, RW'(c), span_r) &&
              !(row_rdata.cur[j] <= FW'(f) && row_rdata.last[j] <= FW'(f))) begin
            win = 1'b0;
          end
        end
        if (win && row_rdata.cnt[f] >= span_r && row_rdata.lcnt[f] >= span_r) begin
          cls_found[f] = 1'b1;
          cls_col[f]   = RW'(c);
        end
      end
    end
    row_found = 1'b0;
    row_f     = '0;
    row_c     = '0;
    for (int f = MAX_FREQ - 1; f >= 0; f--) begin
      if (cls_found[f]) begin
        row_found = 1'b1;
        row_f     = FW'(f);
        row_c     = cls_col[f];
      end
    end
  end

  // A row is kept only if it beats every earlier one on class.
  logic take;
  assign take = row_found && (!best_v_r || row_f < best_f_r);

  // Row word updates.
  logic [GW-1:0] ev_o;
  logic          ev_v;
  row_t          evict_w;
  row_t          map_w;
  row_t          un_w;
  row_t          roll_w;
  row_t          raise_w;
  logic [FW-1:0] rs_f;
  logic [FW-1:0] rs_fn;
  row_t          fresh;

  assign ev_o  = rowq_r.own[bk];
  assign ev_v  = rowq_r.own_v[bk];
  assign rs_f  = rowq_r.cur[bk];
  assign rs_fn = rs_f + 1'b1;
  assign fresh = row_reset();

  always_comb begin
    evict_w = rowq_r;
    map_w   = rowq_r;
    un_w    = row_rdata;
    for (int j = 0; j < EDGE; j++) begin
      // The evicted glyph owns every bucket of this row that carries its index.
      if (ev_v && rowq_r.own_v[j] && rowq_r.own[j] == ev_o) begin
        evict_w.own_v[j] = 1'b0;
      end
      if (in_win(j, tc_r, span_r)) begin
        map_w.own_v[j] = 1'b1;
        map_w.own[j]   = g_r;
      end
      if (in_win(j, ent_r.col, ent_r.span)) begin
        un_w.own_v[j] = 1'b0;
      end
    end
    roll_w      = row_rdata;
    roll_w.last = row_rdata.cur;
    roll_w.cur  = '0;
    roll_w.lcnt = row_rdata.cnt;
    roll_w.cnt  = fresh.cnt;
    raise_w     = rowq_r;
    if (rs_f != FW'(MAX_FREQ - 1)) begin
      raise_w.cnt[rs_f]  = rowq_r.cnt[rs_f] - SW'(1);
      raise_w.cnt[rs_fn] = rowq_r.cnt[rs_fn] + SW'(1);
      raise_w.cur[bk]    = rs_fn;
    end
  end

  // Memory requests.
  always_comb begin
    req              = '0;
    req.row_rd_addr  = rsel_r;
    req.row_wr_addr  = rsel_r;
    req.gmap_rd_addr = (state_r == S_IDLE) ? in_if.glyph_index : g_r;
    unique case (state_r)
      S_UN: begin
        req.row_we    = 1'b1;
        req.row_wdata = un_w;
      end
      S_WB: begin
        req.row_we    = 1'b1;
        req.row_wdata = rowq_r;
      end
      S_ROLL: begin
        req.row_we    = 1'b1;
        req.row_wdata = roll_w;
      end
      S_EVICT: begin
        req.gmap_we      = ev_v;
        req.gmap_wr_addr = ev_o;
        req.gmap_wdata   = '0;
      end
      S_MAP: begin
        req.gmap_we      = 1'b1;
        req.gmap_wr_addr = g_r;
        req.gmap_wdata   = '{mapped: 1'b1, row: rsel_r, col: tc_r, span: span_r};
      end
      default: begin
      end
    endcase
  end

  logic [RW+1:0] place_end;
  assign place_end = {2'b00, in_if.column} + {1'b0, in_if.glyph_span};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid && !busy) begin
            op_r      <= in_if.op;
            g_r       <= in_if.glyph_index;
            span_r    <= in_if.glyph_span;
            row_in_r  <= in_if.row;
            tc_r      <= in_if.column;
            hit_r     <= 1'b0;
            res_row_r <= '0;
            res_col_r <= '0;
            if (in_if.op == OP_FRAME) begin
              res_status_r <= ST_DONE;
              rsel_r       <= '0;
              state_r      <= caching_r ? S_ROLL_W : S_EMIT;
            end else if (in_if.op != OP_USE && in_if.op != OP_PLACE) begin
              res_status_r <= ST_NOROOM;
              state_r      <= S_EMIT;
            end else if (in_if.glyph_span == '0) begin
              res_status_r <= ST_EMPTY;
              state_r      <= S_EMIT;
            end else if (in_if.op == OP_PLACE && place_end > (RW+2)'(EDGE)) begin
              res_status_r <= ST_NOROOM;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_GCHK;
            end
          end
        end
        S_GCHK: begin
          ent_r <= gmap_rdata;
          if (op_r == OP_USE) begin
            if (gmap_rdata.mapped) begin
              res_status_r <= ST_HIT;
              res_row_r    <= gmap_rdata.row;
              res_col_r    <= gmap_rdata.col;
              rsel_r       <= gmap_rdata.row;
              tc_r         <= gmap_rdata.col;
              span_r       <= gmap_rdata.span;
              hit_r        <= 1'b1;
              state_r      <= caching_r ? S_LD_W : S_EMIT;
            end else if (span_r > SW'(EDGE)) begin
              res_status_r <= ST_NOROOM;
              state_r      <= S_EMIT;
            end else begin
              rsel_r   <= '0;
              best_v_r <= 1'b0;
              state_r  <= S_SC_W;
            end
          end else begin
            // Place: a glyph that is already mapped first gives up its buckets.
            rsel_r  <= gmap_rdata.mapped ? gmap_rdata.row : row_in_r;
            state_r <= gmap_rdata.mapped ? S_UN_W : S_LD_W;
          end
        end
        S_SC_W: begin
          state_r <= S_SC;
        end
        S_SC: begin
          if (take) begin
            best_v_r <= 1'b1;
            best_f_r <= row_f;
            best_c_r <= row_c;
            best_r_r <= rsel_r;
          end
          if (rsel_r == RW'(EDGE - 1)) begin
            if (take) begin
              tc_r   <= row_c;
              rsel_r <= rsel_r;
            end else begin
              tc_r   <= best_c_r;
              rsel_r <= best_r_r;
            end
            if (take || best_v_r) begin
              state_r <= S_LD_W;
            end else begin
              res_status_r <= ST_NOROOM;
              state_r      <= S_EMIT;
            end
          end else begin
            rsel_r  <= rsel_r + 1'b1;
            state_r <= S_SC_W;
          end
        end
        S_UN_W: begin
          state_r <= S_UN;
        end
        S_UN: begin
          rsel_r  <= row_in_r;
          state_r <= S_LD_W;
        end
        S_LD_W: begin
          state_r <= S_LD;
        end
        S_LD: begin
          rowq_r  <= row_rdata;
          k_r     <= '0;
          state_r <= hit_r ? S_RAISE : S_EVICT;
        end
        S_EVICT: begin
          rowq_r <= evict_w;
          k_r    <= k_r + 1'b1;
          if (last_k) begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          rowq_r    <= map_w;
          k_r       <= '0;
          res_row_r <= rsel_r;
          res_col_r <= tc_r;
          if (op_r == OP_USE) begin
            res_status_r <= ST_NEW;
            state_r      <= caching_r ? S_RAISE : S_WB;
          end else begin
            res_status_r <= ST_DONE;
            state_r      <= S_WB;
          end
        end
        S_RAISE: begin
          rowq_r <= raise_w;
          k_r    <= k_r + 1'b1;
          if (last_k) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          state_r <= S_EMIT;
        end
        S_ROLL_W: begin
          state_r <= S_ROLL;
        end
        S_ROLL: begin
          rsel_r  <= rsel_r + 1'b1;
          state_r <= (rsel_r == RW'(EDGE - 1)) ? S_EMIT : S_ROLL_W;
        end
        S_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_row_r    <= res_row_r;
            out_col_r    <= res_col_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A finished result always lands in the output register.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_if.ready)) |=> out_valid_r)
    else $error("result not loaded into output register");

  // No item is in work while the clearing pass still owns the memories.
  a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> state_r == S_IDLE || state_r == S_EMIT)
    else $error("item in work during clearing pass");

  // The bucket cursor stays inside the glyph's run.
  a_cursor_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT || state_r == S_RAISE) |-> k_r < span_r && bk_sum < (RW+1)'(EDGE))
    else $error("bucket cursor outside run");
`endif

endmodule

>>> src/gabc_store.sv
// ----------------------------------------------------------------------------
// gabc_store: state memories of the glyph atlas bucket cache
// Row memory and glyph map, registered reads, with a clearing
// pass after reset.
// ----------------------------------------------------------------------------
module gabc_store import gabc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req_i,
  output row_t       row_rdata_o,
  output gmap_t      gmap_rdata_o,
  output logic       busy_o
);

  row_t  row_mem  [EDGE];
  gmap_t gmap_mem [GLYPHS];

  logic [GW:0]   clr_r;
  logic          row_we;
  logic [RW-1:0] row_wa;
  row_t          row_wd;
  logic          gmap_we;
  logic [GW-1:0] gmap_wa;
  gmap_t         gmap_wd;

  // The pass walks the glyph map; the rows are rewritten along the way.
  assign busy_o = ~clr_r[GW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (busy_o) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_comb begin
    row_we  = busy_o ? 1'b1 : req_i.row_we;
    row_wa  = busy_o ? clr_r[RW-1:0] : req_i.row_wr_addr;
    row_wd  = busy_o ? row_reset() : req_i.row_wdata;
    gmap_we = busy_o ? 1'b1 : req_i.gmap_we;
    gmap_wa = busy_o ? clr_r[GW-1:0] : req_i.gmap_wr_addr;
    gmap_wd = busy_o ? '0 : req_i.gmap_wdata;
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_rdata_o <= row_mem[req_i.row_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (gmap_we) begin
      gmap_mem[gmap_wa] <= gmap_wd;
    end
    gmap_rdata_o <= gmap_mem[req_i.gmap_rd_addr];
  end

endmodule
